FILE: sv/fwid_pkg.sv
// Shared types and codes for the FIFO with indexed discard.
package fwid_pkg;

  // Fixed field widths of the streaming payload
  localparam int ModeW   = 2;
  localparam int ElemW   = 32;
  localparam int IndexW  = 4;
  localparam int StatusW = 2;
  localparam int CountW  = 5;
  localparam int InDataW  = 40;  // 38 payload bits padded to whole bytes
  localparam int OutDataW = 40;

  // Operation codes carried in the mode field
  typedef enum logic [ModeW-1:0] {
    MODE_ENQ  = 2'd0,
    MODE_DEQ  = 2'd1,
    MODE_DISC = 2'd2,
    MODE_NOP  = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // Controller to datapath
  typedef struct packed {
    logic              load;     // transaction accepted this cycle
    logic              push;     // write element at the tail
    logic              remove;   // close the gap at rem_idx
    logic [IndexW-1:0] rem_idx;  // position from head to remove
    status_t           res;      // status of this transaction
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_in_range;  // rem_idx below the element count
  } stat_t;

endpackage

FILE: sv/fifo_with_indexed_discard_core.sv
// Top level of the FIFO with indexed discard.
//
// A bounded queue of DEPTH signed elements. Each transaction on the s_ side
// enqueues elem at the tail (mode 0), dequeues the head (mode 1) or discards
// the element at position index from the head (mode 2); later elements close
// the gap. Mode 3 changes nothing. Every transaction produces one result on
// the m_ side: status (done, full, empty, index out of range), the head
// element after the operation (0 when empty), the count and an empty flag.
//
// Latency: the result is valid the cycle after the transaction is accepted.
// Throughput: one transaction per cycle while results are taken; the whole operation, including the
// gap close, is one parallel shift of the element registers.
// The result register frees as its result is taken, so s_tready follows
// m_tready while a result is pending; a stalled receiver holds the result
// and blocks new transactions until it is taken.
// Reset (rst, synchronous) empties the queue and drops any pending result.
module fifo_with_indexed_discard_core #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fwid_pkg::InDataW-1:0]  s_tdata,  // mode[1:0], elem[33:2], index[37:34], pad
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fwid_pkg::OutDataW-1:0] m_tdata   // status[1:0], head_elem[33:2],
                                                  // count[38:34], is_empty[39]
);

  fwid_pkg::cmd_t  cmd;
  fwid_pkg::stat_t stat;

  logic [fwid_pkg::StatusW-1:0] status;
  logic [fwid_pkg::ElemW-1:0]   head_elem;
  logic [fwid_pkg::CountW-1:0]  count;
  logic                         is_empty;

  fwid_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .mode     (s_tdata[1:0]),
    .index    (s_tdata[37:34]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  fwid_dpath #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .elem      (s_tdata[33:2]),
    .status    (status),
    .head_elem (head_elem),
    .count     (count),
    .is_empty  (is_empty)
  );

  // Result packing
  assign m_tdata = {is_empty, count, head_elem, status};

endmodule

FILE: sv/fwid_ctrl.sv
// Controller: decodes each transaction and tracks the pending result.
module fwid_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fwid_pkg::ModeW-1:0]  mode,
  input  logic [fwid_pkg::IndexW-1:0] index,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output fwid_pkg::cmd_t              cmd,
  input  fwid_pkg::stat_t             stat
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t state, state_next;
  logic   accept;

  // A new transaction is taken when no result waits or the waiting one leaves
  assign s_tready = (state == S_IDLE) || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (state == S_HOLD);

  // Operation decode
  always_comb begin
    cmd         = '0;
    cmd.load    = accept;
    cmd.res     = fwid_pkg::ST_DONE;
    cmd.rem_idx = (mode == fwid_pkg::MODE_DEQ) ? '0 : index;
    unique case (fwid_pkg::mode_t'(mode))
      fwid_pkg::MODE_ENQ: begin
        if (stat.full) cmd.res  = fwid_pkg::ST_FULL;
        else           cmd.push = accept;
      end
      fwid_pkg::MODE_DEQ: begin
        if (stat.empty) cmd.res    = fwid_pkg::ST_EMPTY;
        else            cmd.remove = accept;
      end
      fwid_pkg::MODE_DISC: begin
        if (stat.empty)              cmd.res    = fwid_pkg::ST_EMPTY;
        else if (!stat.idx_in_range) cmd.res    = fwid_pkg::ST_RANGE;
        else                         cmd.remove = accept;
      end
      default: ;  // unused code: no change, status done
    endcase
  end

  // Result hand-off state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_HOLD;
      S_HOLD: if (m_tready && !accept) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

endmodule

FILE: sv/fwid_dpath.sv
// Datapath: compacted element registers, fill count and result status.
module fwid_dpath #(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fwid_pkg::cmd_t               cmd,
  output fwid_pkg::stat_t              stat,
  input  logic [fwid_pkg::ElemW-1:0]   elem,
  output logic [fwid_pkg::StatusW-1:0] status,
  output logic [fwid_pkg::ElemW-1:0]   head_elem,
  output logic [fwid_pkg::CountW-1:0]  count,
  output logic                         is_empty
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > fwid_pkg::IndexW) ? CW : fwid_pkg::IndexW;

  typedef logic [fwid_pkg::StatusW-1:0] status_reg_t;

  logic [ELEM_WIDTH-1:0] slots [DEPTH];
  logic [CW-1:0]         fill;
  status_reg_t           res_status;
  logic [ELEM_WIDTH-1:0] elem_st;
  logic [fwid_pkg::ElemW-1:0] head_ext;

  // Fit the input element to the storage width
  generate
    if (ELEM_WIDTH < fwid_pkg::ElemW) begin : g_narrow
      assign elem_st  = elem[ELEM_WIDTH-1:0];
      assign head_ext = {{(fwid_pkg::ElemW - ELEM_WIDTH){slots[0][ELEM_WIDTH-1]}}, slots[0]};
    end else if (ELEM_WIDTH == fwid_pkg::ElemW) begin : g_exact
      assign elem_st  = elem;
      assign head_ext = slots[0];
    end else begin : g_wide
      assign elem_st  = {{(ELEM_WIDTH - fwid_pkg::ElemW){1'b0}}, elem};
      assign head_ext = slots[0][fwid_pkg::ElemW-1:0];
    end
  endgenerate

  // Status back to the controller
  assign stat.full         = (fill == CW'(DEPTH));
  assign stat.empty        = (fill == '0);
  assign stat.idx_in_range = (CMPW'(cmd.rem_idx) < CMPW'(fill));

  // Element registers: tail write or shift toward the head past rem_idx
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.push && (fill == CW'(i))) begin
        slots[i] <= elem_st;
      end else if (cmd.remove && (CMPW'(i) >= CMPW'(cmd.rem_idx)) && (i < DEPTH - 1)) begin
        slots[i] <= slots[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.push) begin
      fill <= fill + CW'(1);
    end else if (cmd.remove) begin
      fill <= fill - CW'(1);
    end
  end

  // Status of the last transaction; head and count follow the state directly
  always_ff @(posedge clk) begin
    if (cmd.load) res_status <= cmd.res;
  end

  assign status    = res_status;
  assign head_elem = stat.empty ? '0 : head_ext;
  assign count     = fwid_pkg::CountW'(fill);
  assign is_empty  = stat.empty;

endmodule

FILE: sv/fwid_checker.sv
// Port-level checks for the FIFO with indexed discard, bound to the top level.
module fwid_checker #(
  parameter int DEPTH = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fwid_pkg::OutDataW-1:0] m_tdata
);

  // Pending result stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // Every accepted transaction yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("no result after accepted transaction");

  // Empty flag agrees with the count (checked only while DEPTH is below 32)
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (DEPTH > 31) || (m_tdata[39] == (m_tdata[38:34] == 5'd0)))
    else $error("empty flag and count disagree");

  // Empty queue reports a zero head
  a_head: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[39] |-> m_tdata[33:2] == 32'd0)
    else $error("nonzero head on empty queue");

  // Full status only at full count
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == fwid_pkg::ST_FULL) |->
      m_tdata[38:34] == fwid_pkg::CountW'(DEPTH))
    else $error("full status below capacity");

endmodule

bind fifo_with_indexed_discard_core fwid_checker #(.DEPTH(DEPTH)) u_fwid_checker (.*);
